/* rtl/ow_pkg.sv */
// Shared types and constants for the one-wire bus master.
// No dependencies; imported by the channel interfaces and the top level.
package ow_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
   localparam int TICK_W        = 10;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 10;

   localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_BYTE - 1);

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_LOW     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRES_HOLD     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRES_TIMEOUT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_START    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_SAMPLE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT          = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY      = 3'd7;

   // register reset values
   localparam logic [9:0] RESET_LOW_DEFAULT    = 10'd480;
   localparam logic [7:0] SETTLE_DEFAULT       = 8'd5;
   localparam logic [9:0] PRES_HOLD_DEFAULT    = 10'd100;
   localparam logic [9:0] PRES_TIMEOUT_DEFAULT = 10'd960;
   localparam logic [3:0] SLOT_START_DEFAULT   = 4'd2;
   localparam logic [6:0] READ_SAMPLE_DEFAULT  = 7'd12;
   localparam logic [6:0] SLOT_DEFAULT         = 7'd68;
   localparam logic [3:0] RECOVERY_DEFAULT     = 4'd2;

   typedef enum logic [1:0] {
      REQ_TICK      = 2'd0,
      REQ_BUS_RESET = 2'd1,
      REQ_WRITE     = 2'd2,
      REQ_READ      = 2'd3
   } req_type_type;

   typedef enum logic [8:0] {
      PH_IDLE       = 9'b000000001,
      PH_RST_LOW    = 9'b000000010,
      PH_RST_SETTLE = 9'b000000100,
      PH_RST_WAIT   = 9'b000001000,
      PH_RST_HOLD   = 9'b000010000,
      PH_W_SLOT     = 9'b000100000,
      PH_W_REC      = 9'b001000000,
      PH_R_SLOT     = 9'b010000000,
      PH_R_REC      = 9'b100000000
   } phase_type;

endpackage

/* rtl/ow_ifs.sv */
// Valid/ready channel interfaces for the one-wire bus master:
// request channel (tick, level, command) and response channel.
// Depends on ow_pkg.
interface ow_req_if import ow_pkg::*; ();
   logic         valid;
   logic         ready;
   req_type_type req_type;
   logic [7:0]   data_byte;
   logic         line_level;

   modport source (output valid, req_type, data_byte, line_level, input ready);
   modport sink   (input valid, req_type, data_byte, line_level, output ready);
endinterface

interface ow_rsp_if import ow_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_data;
   logic       presence;
   logic       rejected;

   modport source (output valid, drive_low, busy_res, done_res, read_data, presence,
                   rejected, input ready);
   modport sink   (input valid, drive_low, busy_res, done_res, read_data, presence,
                   rejected, output ready);
endinterface

/* rtl/one_wire_master_top.sv */
// One-wire bus master top level: sequencer, timing registers, response register.
// Depends on ow_pkg and the channel interfaces in ow_ifs.sv.
//
// Each request is one microsecond tick carrying the sampled bus level and
// optionally a command (bus reset, write byte, read byte); each request
// yields exactly one response describing that tick: the line drive, busy,
// done, read byte, presence and whether a command was rejected because an
// operation was already running. The sequencer state advances in the same
// cycle a request is taken and the response lands in an output register, so
// one request is accepted every clock while the response side keeps up; the
// only stall is a full response register not being taken. The user must write
// timing registers via the csr port only while the bus is idle; not enforced.
module one_wire_master_top import ow_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ow_req_if.sink                req,
   ow_rsp_if.source              rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // timing registers
   logic [9:0] reset_low_ff, pres_hold_ff, pres_timeout_ff;
   logic [7:0] settle_ff;
   logic [3:0] slot_start_ff, recovery_ff;
   logic [6:0] read_sample_ff, slot_ff;

   // sequencer state
   phase_type              phase_ff, phase_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic [BIT_IDX_W-1:0]   bit_ff, bit_in;
   logic [7:0]             shift_ff, shift_in;
   logic                   pres_ff, pres_in;

   // response register
   logic       rsp_valid_ff;
   logic       drive_ff, drive_in;
   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic [7:0] rdata_ff, rdata_in;
   logic       rej_ff, rej_in;

   logic accept;
   logic [TICK_W:0] inc;
   logic [6:0] slot_len;
   logic [9:0] timeout;
   logic is_read;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign slot_len = (slot_ff == 7'd0) ? 7'd1 : slot_ff;
   assign timeout  = (pres_timeout_ff == 10'd0) ? 10'd1 : pres_timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff    <= RESET_LOW_DEFAULT;
         settle_ff       <= SETTLE_DEFAULT;
         pres_hold_ff    <= PRES_HOLD_DEFAULT;
         pres_timeout_ff <= PRES_TIMEOUT_DEFAULT;
         slot_start_ff   <= SLOT_START_DEFAULT;
         read_sample_ff  <= READ_SAMPLE_DEFAULT;
         slot_ff         <= SLOT_DEFAULT;
         recovery_ff     <= RECOVERY_DEFAULT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RESET_LOW:    reset_low_ff    <= csr_wdata[9:0];
            CSR_SETTLE:       settle_ff       <= csr_wdata[7:0];
            CSR_PRES_HOLD:    pres_hold_ff    <= csr_wdata[9:0];
            CSR_PRES_TIMEOUT: pres_timeout_ff <= csr_wdata[9:0];
            CSR_SLOT_START:   slot_start_ff   <= csr_wdata[3:0];
            CSR_READ_SAMPLE:  read_sample_ff  <= csr_wdata[6:0];
            CSR_SLOT:         slot_ff         <= csr_wdata[6:0];
            CSR_RECOVERY:     recovery_ff     <= csr_wdata[3:0];
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      pres_in  = pres_ff;
      drive_in = 1'b0;
      done_in  = 1'b0;
      rdata_in = 8'd0;
      rej_in   = 1'b0;
      is_read  = 1'b0;

      // command decode; a command taken while idle also runs its first tick
      if (phase_ff == PH_IDLE) begin
         unique case (req.req_type)
            REQ_BUS_RESET: begin
               tick_in = '0;
               if (reset_low_ff != 10'd0)   phase_in = PH_RST_LOW;
               else if (settle_ff != 8'd0)  phase_in = PH_RST_SETTLE;
               else                         phase_in = PH_RST_WAIT;
            end
            REQ_WRITE: begin
               shift_in = req.data_byte;
               bit_in   = '0;
               tick_in  = '0;
               phase_in = PH_W_SLOT;
            end
            REQ_READ: begin
               shift_in = 8'd0;
               bit_in   = '0;
               tick_in  = '0;
               phase_in = PH_R_SLOT;
            end
            REQ_TICK: ;
         endcase
      end else if (req.req_type != REQ_TICK) begin
         rej_in = 1'b1;
      end

      inc = {1'b0, tick_in} + 1'b1;

      unique case (phase_in)
         PH_IDLE: ;
         PH_RST_LOW: begin
            drive_in = 1'b1;
            tick_in  = inc[TICK_W-1:0];
            if (inc >= {1'b0, reset_low_ff}) begin
               tick_in  = '0;
               phase_in = (settle_ff != 8'd0) ? PH_RST_SETTLE : PH_RST_WAIT;
            end
         end
         PH_RST_SETTLE: begin
            tick_in = inc[TICK_W-1:0];
            if (inc >= {3'd0, settle_ff}) begin
               tick_in  = '0;
               phase_in = PH_RST_WAIT;
            end
         end
         PH_RST_WAIT: begin
            if (!req.line_level) begin
               pres_in = 1'b1;
               tick_in = '0;
               if (pres_hold_ff == 10'd0) begin
                  done_in  = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_RST_HOLD;
               end
            end else begin
               tick_in = inc[TICK_W-1:0];
               if (inc >= {1'b0, timeout}) begin
                  pres_in  = 1'b0;
                  done_in  = 1'b1;
                  tick_in  = '0;
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_RST_HOLD: begin
            tick_in = inc[TICK_W-1:0];
            if (inc >= {1'b0, pres_hold_ff}) begin
               done_in  = 1'b1;
               tick_in  = '0;
               phase_in = PH_IDLE;
            end
         end
         PH_W_SLOT, PH_R_SLOT: begin
            is_read  = (phase_in == PH_R_SLOT);
            drive_in = (tick_in < {6'd0, slot_start_ff}) ||
                       (!is_read && !shift_in[bit_in]);
            if (is_read && inc == {4'd0, read_sample_ff})
               shift_in[bit_in] = shift_in[bit_in] | req.line_level;
            tick_in = inc[TICK_W-1:0];
            if (inc >= {4'd0, slot_len}) begin
               tick_in = '0;
               if (recovery_ff != 4'd0) begin
                  phase_in = is_read ? PH_R_REC : PH_W_REC;
               end else if (bit_in == LAST_BIT) begin
                  done_in  = 1'b1;
                  rdata_in = is_read ? shift_in : 8'd0;
                  phase_in = PH_IDLE;
               end else begin
                  bit_in   = bit_in + 1'b1;
                  phase_in = is_read ? PH_R_SLOT : PH_W_SLOT;
               end
            end
         end
         PH_W_REC, PH_R_REC: begin
            is_read = (phase_in == PH_R_REC);
            tick_in = inc[TICK_W-1:0];
            if (inc >= {7'd0, recovery_ff}) begin
               tick_in = '0;
               if (bit_in == LAST_BIT) begin
                  done_in  = 1'b1;
                  rdata_in = is_read ? shift_in : 8'd0;
                  phase_in = PH_IDLE;
               end else begin
                  bit_in   = bit_in + 1'b1;
                  phase_in = is_read ? PH_R_SLOT : PH_W_SLOT;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
            tick_in  = '0;
         end
      endcase

      busy_in = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= 8'd0;
         pres_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            tick_ff  <= tick_in;
            bit_ff   <= bit_in;
            shift_ff <= shift_in;
            pres_ff  <= pres_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         drive_ff <= drive_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         rdata_ff <= rdata_in;
         rej_ff   <= rej_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.drive_low = drive_ff;
   assign rsp.busy_res  = busy_ff;
   assign rsp.done_res  = done_ff;
   assign rsp.read_data = rdata_ff;
   assign rsp.presence  = pres_ff;
   assign rsp.rejected  = rej_ff;

`ifndef SYNTH
   // an operation that completed cannot still be running
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(done_ff && busy_ff))
      else $error("done and busy in the same response");

   // read byte is only reported on a done tick
   a_rdata_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rdata_ff != 8'd0) |-> done_ff)
      else $error("read_data nonzero outside done");

   // idle sequencer always has a cleared tick counter
   a_idle_tick_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (tick_ff == '0))
      else $error("tick counter not cleared in idle");

   // a stalled response is never dropped
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> rsp_valid_ff)
      else $error("response dropped while stalled");
`endif

endmodule

/* sim/tb.sv */
// Self-checking bench for the one-wire bus master: request ticks go in through the
// valid/ready channel and every response is checked against a cycle-free predictor.
// Depends on ow_pkg, ow_ifs.sv and one_wire_master_top.
module tb;
   import ow_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 150;
   localparam int RANDOM_ROUNDS  = 3;
   localparam int ROUND_TICKS    = 25;

   typedef struct packed {
      logic       drive_low;
      logic       busy;
      logic       done;
      logic [7:0] read_data;
      logic       presence;
      logic       rejected;
   } bus_rsp_type;

   typedef struct {
      logic [9:0] reset_low;
      logic [7:0] settle;
      logic [9:0] pres_hold;
      logic [9:0] pres_timeout;
      logic [3:0] slot_start;
      logic [6:0] read_sample;
      logic [6:0] slot;
      logic [3:0] recovery;
   } timing_cfg_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   ow_req_if req_if();
   ow_rsp_if rsp_if();

   one_wire_master_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // bus sequencer mirror
   timing_cfg_type cfg;
   phase_type      ph;
   int unsigned    tick_cnt;
   logic [2:0]     bit_idx;
   logic [7:0]     shift_q;
   logic           pres_flag;
   logic           done_now;
   logic [7:0]     read_now;

   bus_rsp_type  expected_rsp_q[$];
   int           errors = 0;
   int           quiet_cycles = 0;
   bit           gaps_on = 1'b1;
   int           hold_request = 0;
   int           hold_left = 0;
   int           stall_left = 0;

   function automatic void enter_phase(phase_type p);
      if (p == PH_RST_LOW && cfg.reset_low == 0) p = PH_RST_SETTLE;
      if (p == PH_RST_SETTLE && cfg.settle == 0) p = PH_RST_WAIT;
      ph = p;
      tick_cnt = 0;
   endfunction

   function automatic void end_op(bit was_read);
      done_now = 1'b1;
      read_now = was_read ? shift_q : 8'h00;
      ph = PH_IDLE;
      tick_cnt = 0;
   endfunction

   function automatic void next_bit(bit is_read);
      if (bit_idx == LAST_BIT) begin
         end_op(is_read);
      end else begin
         bit_idx++;
         if (is_read) ph = PH_R_SLOT;
         else ph = PH_W_SLOT;
         tick_cnt = 0;
      end
   endfunction

   // phase in which the next tick will run, given its request
   function automatic phase_type phase_on_tick(req_type_type rq);
      if (ph != PH_IDLE) return ph;
      case (rq)
         REQ_BUS_RESET: begin
            if (cfg.reset_low != 0) return PH_RST_LOW;
            if (cfg.settle != 0) return PH_RST_SETTLE;
            return PH_RST_WAIT;
         end
         REQ_WRITE: return PH_W_SLOT;
         REQ_READ:  return PH_R_SLOT;
         default:   return PH_IDLE;
      endcase
   endfunction

   function automatic bus_rsp_type bus_tick(req_type_type rq, logic [7:0] data, logic lvl);
      int unsigned slot_len;
      int unsigned wait_len;
      int unsigned c;
      bit          is_read;
      bus_rsp_type r;
      slot_len = (cfg.slot == 0) ? 1 : cfg.slot;
      wait_len = (cfg.pres_timeout == 0) ? 1 : cfg.pres_timeout;
      r = '0;
      done_now = 1'b0;
      read_now = 8'h00;

      // a request taken while idle also runs the first tick of the operation
      if (ph == PH_IDLE) begin
         case (rq)
            REQ_BUS_RESET: enter_phase(PH_RST_LOW);
            REQ_WRITE: begin
               shift_q = data;
               bit_idx = '0;
               enter_phase(PH_W_SLOT);
            end
            REQ_READ: begin
               shift_q = '0;
               bit_idx = '0;
               enter_phase(PH_R_SLOT);
            end
            default: ;
         endcase
      end else if (rq != REQ_TICK) begin
         r.rejected = 1'b1;
      end

      case (ph)
         PH_RST_LOW: begin
            r.drive_low = 1'b1;
            tick_cnt++;
            if (tick_cnt >= cfg.reset_low) enter_phase(PH_RST_SETTLE);
         end
         PH_RST_SETTLE: begin
            tick_cnt++;
            if (tick_cnt >= cfg.settle) enter_phase(PH_RST_WAIT);
         end
         PH_RST_WAIT: begin
            if (!lvl) begin
               pres_flag = 1'b1;
               if (cfg.pres_hold == 0) end_op(1'b0);
               else enter_phase(PH_RST_HOLD);
            end else begin
               tick_cnt++;
               if (tick_cnt >= wait_len) begin
                  pres_flag = 1'b0;
                  end_op(1'b0);
               end
            end
         end
         PH_RST_HOLD: begin
            tick_cnt++;
            if (tick_cnt >= cfg.pres_hold) end_op(1'b0);
         end
         PH_W_SLOT, PH_R_SLOT: begin
            is_read = (ph == PH_R_SLOT);
            c = tick_cnt;
            r.drive_low = (c < cfg.slot_start) || (!is_read && !shift_q[bit_idx]);
            if (is_read && c + 1 == cfg.read_sample) shift_q[bit_idx] = shift_q[bit_idx] | lvl;
            tick_cnt++;
            if (tick_cnt >= slot_len) begin
               if (cfg.recovery == 0) next_bit(is_read);
               else if (is_read) enter_phase(PH_R_REC);
               else enter_phase(PH_W_REC);
            end
         end
         PH_W_REC, PH_R_REC: begin
            tick_cnt++;
            if (tick_cnt >= cfg.recovery) next_bit(ph == PH_R_REC);
         end
         default: begin
            ph = PH_IDLE;
            tick_cnt = 0;
         end
      endcase
      tick_cnt &= 32'h3FF;

      r.busy      = (ph != PH_IDLE);
      r.done      = done_now;
      r.read_data = read_now;
      r.presence  = pres_flag;
      return r;
   endfunction

   // ---------------------------------------------------------------- driving

   task automatic send_tick(req_type_type rq, logic [7:0] data, logic lvl);
      int gap;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.req_type   <= rq;
      req_if.data_byte  <= data;
      req_if.line_level <= lvl;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      expected_rsp_q.push_back(bus_tick(rq, data, lvl));
   endtask

   task automatic wait_drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (expected_rsp_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic apply_cfg(timing_cfg_type c);
      wait_drain();
      write_reg(CSR_RESET_LOW,    c.reset_low);
      write_reg(CSR_SETTLE,       CSR_DATA_W'(c.settle));
      write_reg(CSR_PRES_HOLD,    c.pres_hold);
      write_reg(CSR_PRES_TIMEOUT, c.pres_timeout);
      write_reg(CSR_SLOT_START,   CSR_DATA_W'(c.slot_start));
      write_reg(CSR_READ_SAMPLE,  CSR_DATA_W'(c.read_sample));
      write_reg(CSR_SLOT,         CSR_DATA_W'(c.slot));
      write_reg(CSR_RECOVERY,     CSR_DATA_W'(c.recovery));
      csr_we <= 1'b0;
      cfg = c;
   endtask

   // Issue one request and tick until the bus is idle again. The device answers
   // reset after answer_after high watch ticks (never if negative); a read sees
   // the bits of rd_bits on the line.
   task automatic run_op(req_type_type rq, logic [7:0] data, int answer_after,
                         logic [7:0] rd_bits);
      int           waited;
      phase_type    p;
      logic         lvl;
      req_type_type cur;
      waited = 0;
      cur = rq;
      do begin
         p = phase_on_tick(cur);
         if (p == PH_RST_WAIT) begin
            lvl = (answer_after >= 0 && waited >= answer_after) ? 1'b0 : 1'b1;
            waited++;
         end else if (p == PH_R_SLOT) begin
            lvl = rd_bits[(cur == REQ_TICK) ? bit_idx : 3'd0];
         end else begin
            lvl = 1'($urandom_range(0, 1));
         end
         send_tick(cur, data, lvl);
         cur = REQ_TICK;
      end while (ph != PH_IDLE);
   endtask

   // ------------------------------------------------------------------ tests

   // register reset values: a full bus reset answered by a device
   task automatic test_default_timing();
      run_op(REQ_BUS_RESET, 8'h00, 3, 8'h00);
   endtask

   task automatic test_busy_rejects();
      apply_cfg('{10'd6, 8'd3, 10'd4, 10'd9, 4'd2, 7'd3, 7'd4, 4'd1});
      send_tick(REQ_WRITE, 8'h96, 1'b1);
      send_tick(REQ_BUS_RESET, 8'h00, 1'b1);
      send_tick(REQ_WRITE, 8'hFF, 1'b0);
      send_tick(REQ_READ, 8'h00, 1'b1);
      run_op(REQ_TICK, 8'h00, -1, 8'h00);
      send_tick(REQ_BUS_RESET, 8'h00, 1'b1);
      send_tick(REQ_READ, 8'h00, 1'b1);
      run_op(REQ_TICK, 8'h00, 2, 8'h00);
      send_tick(REQ_READ, 8'h00, 1'b1);
      send_tick(REQ_WRITE, 8'h0F, 1'b1);
      run_op(REQ_TICK, 8'h00, -1, 8'h5A);
   endtask

   // every step length zero, then the shortest slots that still sample
   task automatic test_zero_lengths();
      apply_cfg('{10'd0, 8'd0, 10'd0, 10'd0, 4'd0, 7'd0, 7'd0, 4'd0});
      run_op(REQ_BUS_RESET, 8'h00, 0, 8'h00);
      run_op(REQ_BUS_RESET, 8'h00, -1, 8'h00);
      run_op(REQ_WRITE, 8'h00, -1, 8'h00);
      run_op(REQ_WRITE, 8'hFF, -1, 8'h00);
      run_op(REQ_READ, 8'h00, -1, 8'hFF);
      apply_cfg('{10'd1, 8'd1, 10'd1, 10'd1, 4'd0, 7'd1, 7'd1, 4'd0});
      run_op(REQ_BUS_RESET, 8'h00, 0, 8'h00);
      run_op(REQ_READ, 8'h00, -1, 8'hC3);
      run_op(REQ_WRITE, 8'h69, -1, 8'h00);
   endtask

   // sample point past the slot end with the longest slot opening, then on the
   // last slot tick
   task automatic test_sample_window();
      apply_cfg('{10'd2, 8'd1, 10'd2, 10'd4, 4'd15, 7'd6, 7'd5, 4'd7});
      run_op(REQ_READ, 8'h00, -1, 8'hFF);
      apply_cfg('{10'd2, 8'd1, 10'd2, 10'd4, 4'd3, 7'd5, 7'd5, 4'd1});
      run_op(REQ_READ, 8'h00, -1, 8'hA5);
   endtask

   // response side holds off while requests keep coming, so the block stalls
   task automatic test_backpressure();
      apply_cfg('{10'd3, 8'd2, 10'd5, 10'd12, 4'd2, 7'd3, 7'd3, 4'd1});
      gaps_on = 1'b0;
      hold_request = LONG_HOLD;
      run_op(REQ_WRITE, 8'($urandom_range(0, 255)), -1, 8'h00);
      run_op(REQ_BUS_RESET, 8'h00, 1, 8'h00);
      run_op(REQ_READ, 8'h00, -1, 8'($urandom_range(0, 255)));
      gaps_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      timing_cfg_type c;
      req_type_type   rq;
      phase_type      p;
      logic           lvl;
      for (int round = 0; round < RANDOM_ROUNDS; round++) begin
         c.reset_low    = 10'($urandom_range(0, 8));
         c.settle       = 8'($urandom_range(0, 4));
         c.pres_hold    = 10'($urandom_range(0, 6));
         c.pres_timeout = 10'($urandom_range(0, 10));
         c.slot_start   = 4'($urandom_range(0, 7));
         c.slot         = 7'($urandom_range(0, 6));
         c.read_sample  = 7'($urandom_range(0, 8));
         c.recovery     = 4'($urandom_range(0, 3));
         apply_cfg(c);
         gaps_on = (round != RANDOM_ROUNDS - 1);
         for (int n = 0; n < ROUND_TICKS; n++) begin
            if (ph == PH_IDLE)
               rq = ($urandom_range(0, 3) == 0) ? REQ_TICK : req_type_type'($urandom_range(1, 3));
            else
               rq = ($urandom_range(0, 19) == 0) ? req_type_type'($urandom_range(1, 3)) : REQ_TICK;
            p = phase_on_tick(rq);
            // keep the line mostly high while watching for presence
            lvl = (p == PH_RST_WAIT) ? ($urandom_range(0, 5) != 0) : 1'($urandom_range(0, 1));
            send_tick(rq, 8'($urandom_range(0, 255)), lvl);
            if (gaps_on && $urandom_range(0, 149) == 0) wait_drain();
         end
         run_op(REQ_TICK, 8'h00, 0, 8'($urandom_range(0, 255)));
      end
   endtask

   // --------------------------------------------------------------- checking

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      bus_rsp_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_rsp_q.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("drive_low", 8'(want.drive_low), 8'(rsp_if.drive_low));
            check_field("busy_res",  8'(want.busy),      8'(rsp_if.busy_res));
            check_field("done_res",  8'(want.done),      8'(rsp_if.done_res));
            check_field("read_data", want.read_data,     rsp_if.read_data);
            check_field("presence",  8'(want.presence),  8'(rsp_if.presence));
            check_field("rejected",  8'(want.rejected),  8'(rsp_if.rejected));
         end
      end
   end

   // response-side stalls: random bursts plus the long hold-off on request
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 10) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("one_wire_master_top: mismatch");
            $finish;
         end
      end
   end

   initial begin
      req_if.valid      = 1'b0;
      req_if.req_type   = REQ_TICK;
      req_if.data_byte  = 8'h00;
      req_if.line_level = 1'b1;
      rsp_if.ready      = 1'b0;
      cfg = '{RESET_LOW_DEFAULT, SETTLE_DEFAULT, PRES_HOLD_DEFAULT, PRES_TIMEOUT_DEFAULT,
              SLOT_START_DEFAULT, READ_SAMPLE_DEFAULT, SLOT_DEFAULT, RECOVERY_DEFAULT};
      ph        = PH_IDLE;
      tick_cnt  = 0;
      bit_idx   = '0;
      shift_q   = '0;
      pres_flag = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_default_timing();
      test_busy_rejects();
      test_zero_lengths();
      test_sample_window();
      test_backpressure();
      test_random_traffic();

      wait_drain();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("one_wire_master_top: match");
      else $display("one_wire_master_top: mismatch");
      $finish;
   end

endmodule

/* sim.f */
rtl/ow_pkg.sv
rtl/ow_ifs.sv
rtl/one_wire_master_top.sv
sim/tb.sv
